@@ design/racc_pkg.sv @@
// ----------------------------------------------------------------------------
// racc_pkg: shared constants for the rational accumulator ALU
// Magnitude widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package racc_pkg;

	localparam int MAG_W  = 16;
	localparam int PROD_W = 2 * MAG_W;
	localparam int NUM_W  = PROD_W + 1;
	localparam int CNT_W  = $clog2(NUM_W + 1);

	typedef logic [2:0] func_t;
	typedef logic [1:0] status_t;

	localparam func_t FN_LOAD = 3'd0;
	localparam func_t FN_ADD  = 3'd1;
	localparam func_t FN_SUB  = 3'd2;
	localparam func_t FN_MUL  = 3'd3;
	localparam func_t FN_DIV  = 3'd4;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_ZERO_DIV = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

endpackage

@@ design/rational_accumulator_alu_top.sv @@
// ----------------------------------------------------------------------------
// rational_accumulator_alu_top: sign-magnitude fraction accumulator
//
// One input word carries an operation (load, add, subtract, multiply,
// divide) and an operand fraction. One output word returns the accumulator
// after the step with a status code. Both channels are valid/ready.
// in_ready is high only while the block is idle. A word is taken and worked
// on, and its result is held on the output until out_ready. After that the
// next word can be taken.
// Error and unknown-operation words go straight to the result, and a zero
// result skips the gcd and the divides. Other words use one 16x16 multiplier
// for up to three products, then a single 34-bit subtractor. The subtractor
// is shared by the add/subtract combine, a binary gcd loop and two restoring
// divides of 33 steps each. The gcd loop and the two divides dominate the
// time. The block returns to idle after each result before the next word is
// taken.
// Reset gives an accumulator of 0/1, positive, and an idle block.
// A stalled receiver simply holds the block in its result state.
// ----------------------------------------------------------------------------
module rational_accumulator_alu_top
	import racc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       func,
	input  logic [MAG_W-1:0] operand_num,
	input  logic [MAG_W-1:0] operand_denom,
	input  logic             operand_negative,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [MAG_W-1:0] result_num,
	output logic [MAG_W-1:0] result_denom,
	output logic             result_negative,
	output logic [1:0]       status
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_N, S_MUL_Q, S_MUL_D, S_COMBINE, S_GCD, S_DIV_N, S_DIV_D, S_RESP
	} state_t;

	state_t              state_q;
	func_t               func_q;
	logic [MAG_W-1:0]    bn_q, bd_q;
	logic                bneg_q, neg_q;
	logic [MAG_W-1:0]    acc_num_q, acc_den_q, nq_q;
	logic                acc_neg_q;
	status_t             status_q;
	logic [NUM_W-1:0]    a_q, b_q, num_q;
	logic [PROD_W-1:0]   g_q, den_q;
	logic [CNT_W-1:0]    k_q, cnt_q;

	logic [MAG_W-1:0]    mul_x, mul_y;
	logic [PROD_W-1:0]   prod;
	logic [NUM_W-1:0]    sub_x, sub_y;
	logic [NUM_W:0]      sub_r;
	logic                borrow;
	logic                p_ge_q;
	logic [NUM_W-1:0]    div_r2;
	logic [NUM_W-1:0]    quo_next;
	logic [PROD_W-1:0]   rem_next;
	logic                quo_big;
	logic                opp_neg, same_sign;
	logic [NUM_W-1:0]    comb_num;
	logic                comb_neg;
	logic [PROD_W-1:0]   g_shift;

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = (state_q == S_RESP);
	assign result_num      = acc_num_q;
	assign result_denom    = acc_den_q;
	assign result_negative = acc_neg_q;
	assign status          = status_q;

	// shared multiplier
	always_comb begin
		case (state_q)
			S_MUL_N: begin
				mul_x = acc_num_q;
				mul_y = (func_q == FN_MUL) ? bn_q : bd_q;
			end
			S_MUL_Q: begin
				mul_x = bn_q;
				mul_y = acc_den_q;
			end
			default: begin
				mul_x = acc_den_q;
				mul_y = (func_q == FN_DIV) ? bn_q : bd_q;
			end
		endcase
	end
	assign prod = mul_x * mul_y;

	// shared subtractor
	assign p_ge_q = (a_q >= b_q);
	assign div_r2 = {b_q[PROD_W-1:0], a_q[NUM_W-1]};
	always_comb begin
		case (state_q)
			S_COMBINE: begin
				sub_x = p_ge_q ? a_q : b_q;
				sub_y = p_ge_q ? b_q : a_q;
			end
			S_DIV_N, S_DIV_D: begin
				sub_x = div_r2;
				sub_y = {1'b0, g_q};
			end
			default: begin
				sub_x = a_q;
				sub_y = b_q;
			end
		endcase
	end
	assign sub_r  = {1'b0, sub_x} - {1'b0, sub_y};
	assign borrow = sub_r[NUM_W];

	assign quo_next = {a_q[NUM_W-2:0], ~borrow};
	assign rem_next = borrow ? div_r2[PROD_W-1:0] : sub_r[PROD_W-1:0];
	assign quo_big  = (quo_next[NUM_W-1:MAG_W] != '0);
	assign g_shift  = a_q[PROD_W-1:0] << k_q;

	// sign-magnitude combine of the cross products
	assign opp_neg   = bneg_q ^ (func_q == FN_SUB);
	assign same_sign = (opp_neg == acc_neg_q);
	always_comb begin
		case (func_q)
			FN_ADD, FN_SUB: begin
				if (same_sign) begin
					comb_num = a_q + b_q;
					comb_neg = acc_neg_q;
				end else begin
					comb_num = sub_r[NUM_W-1:0];
					comb_neg = p_ge_q ? acc_neg_q : opp_neg;
				end
			end
			FN_LOAD: begin
				comb_num = a_q;
				comb_neg = bneg_q;
			end
			default: begin
				comb_num = a_q;
				comb_neg = acc_neg_q ^ bneg_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			func_q    <= FN_LOAD;
			bn_q      <= '0;
			bd_q      <= '0;
			bneg_q    <= 1'b0;
			neg_q     <= 1'b0;
			acc_num_q <= '0;
			acc_den_q <= MAG_W'(1);
			acc_neg_q <= 1'b0;
			nq_q      <= '0;
			status_q  <= ST_OK;
			a_q       <= '0;
			b_q       <= '0;
			num_q     <= '0;
			g_q       <= '0;
			den_q     <= '0;
			k_q       <= '0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						bn_q   <= operand_num;
						bd_q   <= operand_denom;
						bneg_q <= operand_negative;
						if (func > FN_DIV) begin
							status_q <= ST_OK;
							state_q  <= S_RESP;
						end else if (operand_denom == '0) begin
							status_q <= ST_ZERO_DIV;
							state_q  <= S_RESP;
						end else if (func == FN_DIV && operand_num == '0) begin
							status_q <= ST_ZERO_DIV;
							state_q  <= S_RESP;
						end else if (func == FN_LOAD) begin
							a_q     <= NUM_W'(operand_num);
							den_q   <= PROD_W'(operand_denom);
							state_q <= S_COMBINE;
						end else begin
							state_q <= S_MUL_N;
						end
					end
				end
				S_MUL_N: begin
					a_q     <= {1'b0, prod};
					state_q <= (func_q == FN_ADD || func_q == FN_SUB) ? S_MUL_Q : S_MUL_D;
				end
				S_MUL_Q: begin
					b_q     <= {1'b0, prod};
					state_q <= S_MUL_D;
				end
				S_MUL_D: begin
					den_q   <= prod;
					state_q <= S_COMBINE;
				end
				S_COMBINE: begin
					num_q <= comb_num;
					neg_q <= comb_neg;
					if (comb_num == '0) begin
						acc_num_q <= '0;
						acc_den_q <= MAG_W'(1);
						acc_neg_q <= 1'b0;
						status_q  <= ST_OK;
						state_q   <= S_RESP;
					end else begin
						a_q     <= comb_num;
						b_q     <= {1'b0, den_q};
						k_q     <= '0;
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					// binary gcd, both operands nonzero
					if (sub_r == '0) begin
						g_q     <= g_shift;
						a_q     <= num_q;
						b_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV_N;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (borrow) begin
						a_q <= b_q;
						b_q <= a_q;
					end else begin
						a_q <= sub_r[NUM_W-1:0] >> 1;
					end
				end
				S_DIV_N: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						if (quo_big) begin
							status_q <= ST_OVERFLOW;
							state_q  <= S_RESP;
						end else begin
							nq_q    <= quo_next[MAG_W-1:0];
							a_q     <= {1'b0, den_q};
							b_q     <= '0;
							cnt_q   <= '0;
							state_q <= S_DIV_D;
						end
					end else begin
						a_q   <= quo_next;
						b_q   <= {1'b0, rem_next};
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV_D: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						if (quo_big) begin
							status_q <= ST_OVERFLOW;
						end else begin
							acc_num_q <= nq_q;
							acc_den_q <= quo_next[MAG_W-1:0];
							acc_neg_q <= neg_q;
							status_q  <= ST_OK;
						end
						state_q <= S_RESP;
					end else begin
						a_q   <= quo_next;
						b_q   <= {1'b0, rem_next};
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RESP: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
